// ===== rtl/rcw_pkg.sv =====
// Shared types and constants of the RGB 3x3 convolution block.
`default_nettype none

package rcw_pkg;

    // Field and register widths
    localparam int PIX_W       = 8;
    localparam int PIXEL_W     = 3 * PIX_W;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = PIX_W + COEF_W;
    localparam int CFG_DATA_W  = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int WIDTH_REG_W = 11;
    localparam int HEIGHT_W    = 16;
    localparam int KSIZE       = 3;

    // Configuration reset values
    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = 16'd480;

    // Output queue sizing
    localparam int OQ_DEPTH  = 16;
    localparam int OQ_AW     = 4;
    localparam int OQ_CRED_W = 6;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_COEF_TOP     = 3'd2,
        CFG_COEF_MID     = 3'd3,
        CFG_COEF_BOTTOM  = 3'd4
    } cfg_idx_t;

    // Per-item control carried from the input stage to the line stage
    typedef struct packed {
        logic mask_top;
        logic mask_mid;
        logic clear;
        logic emit_a;
        logic emit_b;
        logic last_row;
    } s1_ctrl_t;

    // One result item as held in the output queue
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last_pix;
    } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/rgb_conv3x3_wrap_core.sv =====
// Top level: streaming 3x3 convolution of RGB pixels with byte wraparound.
// Throughput: one item per cycle when not stalled; the 16-entry output queue reserves two slots per item.
// Pipeline: the item that completes a window passes the input stage, line RAM read, tap multiply,
//   sum and queue write before its result leaves.
// Reset: counters, pipeline valids, window and queue pointers are cleared; config takes reset values.
// The line RAM is not cleared; rows above the image top are masked to zero instead.
`default_nettype none

module rgb_conv3x3_wrap_core
    import rcw_pkg::*;
#(
    parameter int MAX_WIDTH      = 1024,
    parameter int COEF_FRAC_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [PIX_W-1:0]      red_in,
    input  wire logic [PIX_W-1:0]      green_in,
    input  wire logic [PIX_W-1:0]      blue_in,
    input  wire logic                  flush_item,
    // output channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [PIX_W-1:0]           red_out,
    output logic [PIX_W-1:0]           green_out,
    output logic [PIX_W-1:0]           blue_out,
    output logic                       last_pixel
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;

    // Configuration registers
    logic [WIDTH_REG_W-1:0] width_reg;
    logic [HEIGHT_W-1:0]    height_reg;
    logic [CFG_DATA_W-1:0]  coef_reg [KSIZE];

    // Position counters
    logic [CW-1:0]       col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;

    // Input stage signals
    logic            in_accept;
    logic [WW-1:0]   w_eff;
    logic            end_row;
    logic            row_ge_h;
    logic            emit_ok;
    logic [PIXEL_W-1:0] pix0;
    s1_ctrl_t        ctrl0;

    // Line stage registers
    logic               s1_valid_reg;
    logic [CW-1:0]      s1_addr_reg;
    logic [PIXEL_W-1:0] s1_pix_reg;
    s1_ctrl_t           s1_ctrl_reg;
    logic               fwd_hit_reg;
    logic [2*PIXEL_W-1:0] fwd_data_reg;

    // Line RAM ports
    logic [2*PIXEL_W-1:0] ram_rd_data;
    logic [2*PIXEL_W-1:0] ram_wr_data;
    logic [2*PIXEL_W-1:0] line_raw;
    logic [PIXEL_W-1:0]   line_prev;
    logic [PIXEL_W-1:0]   line_older;

    // Window
    logic [PIXEL_W-1:0] win_reg  [KSIZE][KSIZE];
    logic [PIXEL_W-1:0] win_next [KSIZE][KSIZE];
    logic [PIXEL_W-1:0] win_base [KSIZE][KSIZE];
    logic [PIXEL_W-1:0] col_in   [KSIZE];

    // Multiply stage
    logic s2_valid_reg, s2_emit_a_reg, s2_emit_b_reg, s2_last_reg;
    logic [PROD_W-1:0] prod_a [KSIZE][KSIZE][KSIZE];
    logic [PROD_W-1:0] prod_b [KSIZE][KSIZE][KSIZE-1];

    // Sum stage
    logic s3_valid_reg, s3_emit_a_reg, s3_emit_b_reg, s3_last_reg;
    logic [PIX_W-1:0] pa_reg [KSIZE][KSIZE][KSIZE];
    logic [PIX_W-1:0] pb_reg [KSIZE][KSIZE][KSIZE-1];
    logic [PIX_W-1:0] sum_a [KSIZE];
    logic [PIX_W-1:0] sum_b [KSIZE];
    out_item_t        item_a, item_b;

    // Output queue
    out_item_t        oq_data_reg [OQ_DEPTH];
    logic [OQ_AW-1:0] oq_wptr_reg, oq_wptr_next;
    logic [OQ_AW-1:0] oq_rptr_reg, oq_rptr_next;
    logic [OQ_AW:0]   oq_count_reg, oq_count_next;
    logic             push_a, push_b, pop;
    logic [OQ_AW-1:0] wb_idx;
    logic [OQ_CRED_W-1:0] credit_used;
    out_item_t        head;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            coef_reg[0] <= '0;
            coef_reg[1] <= '0;
            coef_reg[2] <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_IMAGE_WIDTH:  width_reg   <= cfg_data[WIDTH_REG_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg  <= cfg_data[HEIGHT_W-1:0];
                CFG_COEF_TOP:     coef_reg[0] <= cfg_data;
                CFG_COEF_MID:     coef_reg[1] <= cfg_data;
                CFG_COEF_BOTTOM:  coef_reg[2] <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Reserve two queue slots per item in flight
    always_comb
    begin
        credit_used = OQ_CRED_W'(oq_count_reg)
                    + OQ_CRED_W'({s1_valid_reg, 1'b0})
                    + OQ_CRED_W'({s2_valid_reg, 1'b0})
                    + OQ_CRED_W'({s3_valid_reg, 1'b0});
        in_stall    = credit_used > OQ_CRED_W'(OQ_DEPTH - 2);
    end

    assign in_accept = in_valid && !in_stall;

    // Decode position, clamp width and classify the item
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (WW'(width_reg) > WW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_reg);
        end
        end_row  = (WW'(col_reg) + WW'(1)) >= w_eff;
        row_ge_h = row_reg >= height_reg;
        emit_ok  = (row_reg != '0) && (row_reg <= height_reg);
        pix0     = (flush_item || row_ge_h) ? '0 : {blue_in, green_in, red_in};

        ctrl0.mask_top = row_reg > HEIGHT_W'(1);
        ctrl0.mask_mid = row_reg != '0;
        ctrl0.clear    = col_reg == '0;
        ctrl0.emit_a   = emit_ok && (col_reg != '0);
        ctrl0.emit_b   = emit_ok && end_row;
        ctrl0.last_row = row_reg == height_reg;

        col_next = col_reg;
        row_next = row_reg;
        if (in_accept)
        begin
            if (end_row)
            begin
                col_next = '0;
                row_next = row_ge_h ? '0 : row_reg + HEIGHT_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    // Advance position counters and the line stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= in_accept;
            fwd_hit_reg  <= in_accept && s1_valid_reg && (col_reg == s1_addr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_addr_reg <= col_reg;
            s1_pix_reg  <= pix0;
            s1_ctrl_reg <= ctrl0;
        end
        fwd_data_reg <= ram_wr_data;
    end

    // Line RAM: upper half holds the row two back, lower half the row before
    rcw_ram #(
        .WIDTH (2 * PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (ram_wr_data),
        .rd_en   (in_accept),
        .rd_addr (col_reg),
        .rd_data (ram_rd_data)
    );

    // Forward the last write when the next item reads the same column
    always_comb
    begin
        line_raw    = fwd_hit_reg ? fwd_data_reg : ram_rd_data;
        line_prev   = line_raw[PIXEL_W-1:0];
        line_older  = line_raw[2*PIXEL_W-1:PIXEL_W];
        ram_wr_data = {line_prev, s1_pix_reg};
    end

    // Shift the new column into the window, cleared at row start
    always_comb
    begin
        col_in[0] = s1_ctrl_reg.mask_top ? line_older : '0;
        col_in[1] = s1_ctrl_reg.mask_mid ? line_prev  : '0;
        col_in[2] = s1_pix_reg;
        for (int r = 0; r < KSIZE; r++)
        begin
            for (int k = 0; k < KSIZE; k++)
            begin
                win_base[r][k] = s1_ctrl_reg.clear ? '0 : win_reg[r][k];
            end
            win_next[r][0] = win_base[r][1];
            win_next[r][1] = win_base[r][2];
            win_next[r][2] = col_in[r];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < KSIZE; r++)
            begin
                for (int k = 0; k < KSIZE; k++)
                begin
                    win_reg[r][k] <= '0;
                end
            end
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_valid_reg)
            begin
                win_reg <= win_next;
            end
            s2_valid_reg <= s1_valid_reg && (s1_ctrl_reg.emit_a || s1_ctrl_reg.emit_b);
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Multiply every tap; the right-flush result sees the window one column on
    always_comb
    begin
        for (int ch = 0; ch < KSIZE; ch++)
        begin
            for (int r = 0; r < KSIZE; r++)
            begin
                for (int k = 0; k < KSIZE; k++)
                begin
                    prod_a[ch][r][k] = PROD_W'(win_reg[r][k][ch*PIX_W +: PIX_W])
                                     * PROD_W'(coef_reg[r][k*COEF_W +: COEF_W]);
                end
                for (int k = 0; k < KSIZE - 1; k++)
                begin
                    prod_b[ch][r][k] = PROD_W'(win_reg[r][k+1][ch*PIX_W +: PIX_W])
                                     * PROD_W'(coef_reg[r][k*COEF_W +: COEF_W]);
                end
            end
        end
    end

    // Register the integer byte of each product
    always_ff @(posedge clk)
    begin
        s2_emit_a_reg <= s1_ctrl_reg.emit_a;
        s2_emit_b_reg <= s1_ctrl_reg.emit_b;
        s2_last_reg   <= s1_ctrl_reg.last_row;
        s3_emit_a_reg <= s2_emit_a_reg;
        s3_emit_b_reg <= s2_emit_b_reg;
        s3_last_reg   <= s2_last_reg;
        for (int ch = 0; ch < KSIZE; ch++)
        begin
            for (int r = 0; r < KSIZE; r++)
            begin
                for (int k = 0; k < KSIZE; k++)
                begin
                    pa_reg[ch][r][k] <= prod_a[ch][r][k][COEF_FRAC_BITS +: PIX_W];
                end
                for (int k = 0; k < KSIZE - 1; k++)
                begin
                    pb_reg[ch][r][k] <= prod_b[ch][r][k][COEF_FRAC_BITS +: PIX_W];
                end
            end
        end
    end

    // Sum the taps modulo 256
    always_comb
    begin
        for (int ch = 0; ch < KSIZE; ch++)
        begin
            sum_a[ch] = '0;
            sum_b[ch] = '0;
            for (int r = 0; r < KSIZE; r++)
            begin
                for (int k = 0; k < KSIZE; k++)
                begin
                    sum_a[ch] = sum_a[ch] + pa_reg[ch][r][k];
                end
                for (int k = 0; k < KSIZE - 1; k++)
                begin
                    sum_b[ch] = sum_b[ch] + pb_reg[ch][r][k];
                end
            end
        end
        item_a = '{red: sum_a[0], green: sum_a[1], blue: sum_a[2], last_pix: 1'b0};
        item_b = '{red: sum_b[0], green: sum_b[1], blue: sum_b[2], last_pix: s3_last_reg};
    end

    // Queue pointers: push up to two items, pop one
    always_comb
    begin
        push_a        = s3_valid_reg && s3_emit_a_reg;
        push_b        = s3_valid_reg && s3_emit_b_reg;
        pop           = out_valid && !out_stall;
        wb_idx        = push_a ? oq_wptr_reg + OQ_AW'(1) : oq_wptr_reg;
        oq_wptr_next  = oq_wptr_reg + OQ_AW'(push_a) + OQ_AW'(push_b);
        oq_rptr_next  = oq_rptr_reg + OQ_AW'(pop);
        oq_count_next = oq_count_reg + (OQ_AW + 1)'(push_a) + (OQ_AW + 1)'(push_b)
                      - (OQ_AW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wptr_reg  <= '0;
            oq_rptr_reg  <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            oq_wptr_reg  <= oq_wptr_next;
            oq_rptr_reg  <= oq_rptr_next;
            oq_count_reg <= oq_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            oq_data_reg[oq_wptr_reg] <= item_a;
        end
        if (push_b)
        begin
            oq_data_reg[wb_idx] <= item_b;
        end
    end

    // Present the queue head
    always_comb
    begin
        head       = oq_data_reg[oq_rptr_reg];
        out_valid  = oq_count_reg != '0;
        red_out    = head.red;
        green_out  = head.green;
        blue_out   = head.blue;
        last_pixel = head.last_pix;
    end

endmodule

`default_nettype wire

// ===== rtl/rcw_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module rcw_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and read the old contents on an address collision
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rcw_chk.sv =====
// Port-level checker for the RGB 3x3 convolution block, with its bind.
`default_nettype none

module rcw_chk
    import rcw_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_stall,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire logic [PIX_W-1:0] red_out,
    input wire logic [PIX_W-1:0] green_out,
    input wire logic [PIX_W-1:0] blue_out,
    input wire logic             last_pixel
);

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(red_out) && $stable(green_out)
                                   && $stable(blue_out) && $stable(last_pixel))
        else $error("stalled result item changed");

    // An empty output queue always leaves room for a new item
    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output queue is empty");

    // A result into an empty queue must follow an accepted input item
    a_first_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 4))
        else $error("result item appeared without a matching input item");

endmodule

bind rgb_conv3x3_wrap_core rcw_chk u_rcw_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .last_pixel (last_pixel)
);

`default_nettype wire
